// ===== src/hbp_pkg.sv =====
// Shared types, constants and counter helpers of the hybrid branch predictor.
`timescale 1ns / 1ps

package hbp_pkg;

  // Default table index widths (top-level parameter defaults).
  parameter int unsigned DEF_CHOOSER_BITS = 12;
  parameter int unsigned DEF_GSHARE_BITS  = 12;
  parameter int unsigned DEF_BIMODAL_BITS = 12;

  parameter int unsigned ADDR_W = 32;
  parameter int unsigned CFG_W  = 4;
  parameter int unsigned HIST_W = 12;
  parameter int unsigned CTR_W  = 3;
  parameter int unsigned CHS_W  = 2;

  parameter logic [CTR_W-1:0] CTR_MAX   = 3'd7;
  parameter logic [CTR_W-1:0] CTR_RESET = 3'd4;
  parameter logic [CTR_W-1:0] TAKEN_AT  = 3'd4;
  parameter logic [CHS_W-1:0] CHS_MAX   = 2'd3;
  parameter logic [CHS_W-1:0] CHS_RESET = 2'd1;
  parameter logic [CHS_W-1:0] GSHARE_AT = 2'd2;

  parameter logic [CFG_W-1:0] RST_CHOOSER_BITS = 4'd8;
  parameter logic [CFG_W-1:0] RST_GSHARE_BITS  = 4'd9;
  parameter logic [CFG_W-1:0] RST_HISTORY_BITS = 4'd9;
  parameter logic [CFG_W-1:0] RST_BIMODAL_BITS = 4'd8;

  typedef enum logic [1:0] {
    REG_CHOOSER_BITS = 2'd0,
    REG_GSHARE_BITS  = 2'd1,
    REG_HISTORY_BITS = 2'd2,
    REG_BIMODAL_BITS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [ADDR_W-1:0] branch_address;
    logic              taken;
  } req_t;

  typedef struct packed {
    logic predicted_taken;
    logic used_gshare;
    logic gshare_guess;
    logic bimodal_guess;
    logic mispredicted;
  } rsp_t;

  typedef struct packed {
    logic [CFG_W-1:0] chooser_bits;
    logic [CFG_W-1:0] gshare_bits;
    logic [CFG_W-1:0] history_bits;
    logic [CFG_W-1:0] bimodal_bits;
  } cfg_t;

  // History update issued when a branch retires from the lookup stage.
  typedef struct packed {
    logic en;
    logic taken;
  } hist_upd_t;

  function automatic logic [CTR_W-1:0] ctr_train(logic [CTR_W-1:0] v, logic up);
    logic [CTR_W-1:0] r;
    r = v;
    if (up) begin
      if (v != CTR_MAX) r = v + CTR_W'(1);
    end else begin
      if (v != '0) r = v - CTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [CHS_W-1:0] chs_train(logic [CHS_W-1:0] v, logic g_right,
                                                 logic b_right);
    logic [CHS_W-1:0] r;
    r = v;
    if (g_right && !b_right) begin
      if (v != CHS_MAX) r = v + CHS_W'(1);
    end else if (b_right && !g_right) begin
      if (v != '0) r = v - CHS_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/hbp_table.sv =====
// Synchronous counter table with one read and one write port, write-first on collision.
`timescale 1ns / 1ps

module hbp_table #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 3
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  localparam int unsigned Depth = 2 ** AW;

  logic [DW-1:0] mem_q [Depth];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Forward the value being written when the read hits the same entry.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/hbp_index.sv =====
// Global history register and table index generation.
`timescale 1ns / 1ps

module hbp_index #(
  parameter int unsigned CW = hbp_pkg::DEF_CHOOSER_BITS,
  parameter int unsigned GW = hbp_pkg::DEF_GSHARE_BITS,
  parameter int unsigned BW = hbp_pkg::DEF_BIMODAL_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hbp_pkg::cfg_t               cfg_i,
  input  hbp_pkg::hist_upd_t          upd_i,
  input  logic [hbp_pkg::ADDR_W-1:0]  addr_i,
  output logic [CW-1:0]               c_idx_o,
  output logic [GW-1:0]               g_idx_o,
  output logic [BW-1:0]               b_idx_o
);

  localparam int unsigned HW = hbp_pkg::HIST_W;

  logic [hbp_pkg::ADDR_W-3:0] word;
  logic [hbp_pkg::CFG_W-1:0]  hbits;
  logic [HW-1:0]              hmask, hist_q, hist_cur, hist_sh, hist_next, hist_eff;
  logic [GW-1:0]              hist_x;

  assign word  = addr_i[hbp_pkg::ADDR_W-1:2];
  assign hbits = (cfg_i.history_bits > hbp_pkg::CFG_W'(HW)) ? hbp_pkg::CFG_W'(HW)
                                                            : cfg_i.history_bits;

  always_comb begin
    for (int i = 0; i < HW; i++) begin
      hmask[i] = (i < int'(hbits));
    end
    hist_cur = hist_q & hmask;
    hist_sh  = {1'b0, hist_cur[HW-1:1]};
    for (int i = 0; i < HW; i++) begin
      hist_next[i] = hmask[i] & (hist_sh[i] | (upd_i.taken && ((i + 1) == int'(hbits))));
    end
    // A branch retiring in this cycle already counts for the next lookup.
    hist_eff = upd_i.en ? hist_next : hist_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (upd_i.en) begin
      hist_q <= hist_next;
    end
  end

  assign hist_x = GW'(hist_eff);

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      c_idx_o[i] = word[i] & (i < int'(cfg_i.chooser_bits));
    end
    for (int i = 0; i < GW; i++) begin
      g_idx_o[i] = (word[i] ^ hist_x[i]) & (i < int'(cfg_i.gshare_bits));
    end
    for (int i = 0; i < BW; i++) begin
      b_idx_o[i] = word[i] & (i < int'(cfg_i.bimodal_bits));
    end
  end

endmodule

// ===== src/hybrid_branch_predictor_top.sv =====
// Top level of the tournament (gshare plus bimodal) branch predictor.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid_i / req_ready_o / req_i) carries one resolved
//   branch: its byte address and its outcome. Response channel (rsp_valid_o /
//   rsp_ready_i / rsp_o) returns one item per request: both component guesses,
//   the chooser's pick, the final prediction and a mispredict flag.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
//   clock edge; write only while no request is in flight.
// Lookup: a request accepted at an edge reads all three tables into their read
//   registers at that edge; the response register loads when the lookup retires.
// Throughput: one request per cycle when not stalled. The lookup stage writes
//   back the trained counters in the same cycle the next request reads; each
//   table forwards the written value on a same-entry collision, and the global
//   history feeds the retiring branch's outcome straight into the next gshare index.
// Reset: history clears and the registers take their reset values; then a
//   clearing pass sweeps all tables over 2**max(table index widths) addresses
//   (4096 at default parameters), during which req_ready_o stays low.
// Stall: while rsp_ready_i is low the response register holds; one more request
//   may sit in the lookup stage, after which req_ready_o drops.
module hybrid_branch_predictor_top #(
  parameter int unsigned MAX_CHOOSER_BITS = hbp_pkg::DEF_CHOOSER_BITS,
  parameter int unsigned MAX_GSHARE_BITS  = hbp_pkg::DEF_GSHARE_BITS,
  parameter int unsigned MAX_BIMODAL_BITS = hbp_pkg::DEF_BIMODAL_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  hbp_pkg::req_t             req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output hbp_pkg::rsp_t             rsp_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [hbp_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CW    = MAX_CHOOSER_BITS;
  localparam int unsigned GW    = MAX_GSHARE_BITS;
  localparam int unsigned BW    = MAX_BIMODAL_BITS;
  localparam int unsigned CgMax = (CW > GW) ? CW : GW;
  localparam int unsigned ClrW  = (CgMax > BW) ? CgMax : BW;

  // Configuration registers.
  hbp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chooser_bits <= hbp_pkg::RST_CHOOSER_BITS;
      cfg_q.gshare_bits  <= hbp_pkg::RST_GSHARE_BITS;
      cfg_q.history_bits <= hbp_pkg::RST_HISTORY_BITS;
      cfg_q.bimodal_bits <= hbp_pkg::RST_BIMODAL_BITS;
    end else if (cfg_we_i) begin
      unique case (hbp_pkg::cfg_reg_e'(cfg_idx_i))
        hbp_pkg::REG_CHOOSER_BITS: cfg_q.chooser_bits <= cfg_wdata_i;
        hbp_pkg::REG_GSHARE_BITS:  cfg_q.gshare_bits  <= cfg_wdata_i;
        hbp_pkg::REG_HISTORY_BITS: cfg_q.history_bits <= cfg_wdata_i;
        hbp_pkg::REG_BIMODAL_BITS: cfg_q.bimodal_bits <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clearing pass after reset.
  logic            clr_q;
  logic [ClrW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + ClrW'(1);
      if (clr_cnt_q == '1) clr_q <= 1'b0;
    end
  end

  // Lookup stage and response register.
  logic            s1_valid_q;
  logic            taken_q;
  logic [CW-1:0]   c_idx_q;
  logic [GW-1:0]   g_idx_q;
  logic [BW-1:0]   b_idx_q;
  logic            rsp_valid_q;
  hbp_pkg::rsp_t   rsp_q;

  logic            req_acc, s1_done;
  logic [CW-1:0]   c_idx;
  logic [GW-1:0]   g_idx;
  logic [BW-1:0]   b_idx;
  hbp_pkg::hist_upd_t hist_upd;

  // Retire the lookup once the response register is free or being drained.
  assign s1_done     = s1_valid_q && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !clr_q && (!s1_valid_q || s1_done);
  assign req_acc     = req_valid_i && req_ready_o;

  assign hist_upd.en    = s1_done;
  assign hist_upd.taken = taken_q;

  hbp_index #(
    .CW (CW),
    .GW (GW),
    .BW (BW)
  ) u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .upd_i   (hist_upd),
    .addr_i  (req_i.branch_address),
    .c_idx_o (c_idx),
    .g_idx_o (g_idx),
    .b_idx_o (b_idx)
  );

  // Table write ports: sweep during clear, otherwise train on retire.
  logic [hbp_pkg::CHS_W-1:0] c_ctr, c_wdata;
  logic [hbp_pkg::CTR_W-1:0] g_ctr, b_ctr, g_wdata, b_wdata;
  logic [CW-1:0]             c_waddr;
  logic [GW-1:0]             g_waddr;
  logic [BW-1:0]             b_waddr;
  logic                      c_we, g_we, b_we;
  logic                      use_g, g_guess, b_guess, pred;

  always_comb begin
    use_g   = (c_ctr >= hbp_pkg::GSHARE_AT);
    g_guess = (g_ctr >= hbp_pkg::TAKEN_AT);
    b_guess = (b_ctr >= hbp_pkg::TAKEN_AT);
    pred    = use_g ? g_guess : b_guess;

    if (clr_q) begin
      c_we    = 1'b1;
      g_we    = 1'b1;
      b_we    = 1'b1;
      c_waddr = CW'(clr_cnt_q);
      g_waddr = GW'(clr_cnt_q);
      b_waddr = BW'(clr_cnt_q);
      c_wdata = hbp_pkg::CHS_RESET;
      g_wdata = hbp_pkg::CTR_RESET;
      b_wdata = hbp_pkg::CTR_RESET;
    end else begin
      c_we    = s1_done;
      g_we    = s1_done && use_g;
      b_we    = s1_done && !use_g;
      c_waddr = c_idx_q;
      g_waddr = g_idx_q;
      b_waddr = b_idx_q;
      c_wdata = hbp_pkg::chs_train(c_ctr, g_guess == taken_q, b_guess == taken_q);
      g_wdata = hbp_pkg::ctr_train(g_ctr, taken_q);
      b_wdata = hbp_pkg::ctr_train(b_ctr, taken_q);
    end
  end

  hbp_table #(.AW(CW), .DW(hbp_pkg::CHS_W)) u_chooser (
    .clk_i     (clk_i),
    .rd_en_i   (req_acc),
    .rd_addr_i (c_idx),
    .wr_en_i   (c_we),
    .wr_addr_i (c_waddr),
    .wr_data_i (c_wdata),
    .rd_data_o (c_ctr)
  );

  hbp_table #(.AW(GW), .DW(hbp_pkg::CTR_W)) u_gshare (
    .clk_i     (clk_i),
    .rd_en_i   (req_acc),
    .rd_addr_i (g_idx),
    .wr_en_i   (g_we),
    .wr_addr_i (g_waddr),
    .wr_data_i (g_wdata),
    .rd_data_o (g_ctr)
  );

  hbp_table #(.AW(BW), .DW(hbp_pkg::CTR_W)) u_bimodal (
    .clk_i     (clk_i),
    .rd_en_i   (req_acc),
    .rd_addr_i (b_idx),
    .wr_en_i   (b_we),
    .wr_addr_i (b_waddr),
    .wr_data_i (b_wdata),
    .rd_data_o (b_ctr)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload: hold indexes for write-back, load the response on retire.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      taken_q <= req_i.taken;
      c_idx_q <= c_idx;
      g_idx_q <= g_idx;
      b_idx_q <= b_idx;
    end
    if (s1_done) begin
      rsp_q.predicted_taken <= pred;
      rsp_q.used_gshare     <= use_g;
      rsp_q.gshare_guess    <= g_guess;
      rsp_q.bimodal_guess   <= b_guess;
      rsp_q.mispredicted    <= pred ^ taken_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== bench/hybrid_branch_predictor_top_test.sv =====
// Self-checking testbench for the tournament branch predictor top level.
`timescale 1ns / 1ps

module hybrid_branch_predictor_top_test;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned LONG_HOLD = 64;
  localparam int unsigned POOL_SIZE = 8;
  localparam int unsigned PRINT_CAP = 20;

  // Outcome styles for the branches of the address pool. Loops and correlated
  // branches let the counters saturate and the chooser swing both ways.
  typedef enum logic [2:0] {
    LOOP_TAKEN,
    LOOP_NOT_TAKEN,
    LOOP_EXIT,
    CORRELATED,
    COIN_FLIP
  } outcome_style_e;

  logic                      clk;
  logic                      rst_n;
  logic                      req_valid;
  logic                      req_ready_o;
  hbp_pkg::req_t             req;
  logic                      rsp_valid_o;
  logic                      rsp_ready;
  hbp_pkg::rsp_t             rsp_o;
  logic                      cfg_we;
  logic [1:0]                cfg_idx;
  logic [hbp_pkg::CFG_W-1:0] cfg_wdata;

  hybrid_branch_predictor_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready_o),
    .req_i       (req),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Predictor state: the three counter tables, the global history and the
  // width registers as the block should hold them.
  logic [hbp_pkg::CHS_W-1:0] chooser_ctr [0:(1 << hbp_pkg::DEF_CHOOSER_BITS) - 1];
  logic [hbp_pkg::CTR_W-1:0] gshare_ctr  [0:(1 << hbp_pkg::DEF_GSHARE_BITS) - 1];
  logic [hbp_pkg::CTR_W-1:0] bimodal_ctr [0:(1 << hbp_pkg::DEF_BIMODAL_BITS) - 1];
  logic [hbp_pkg::HIST_W-1:0] global_hist;
  logic [hbp_pkg::CFG_W-1:0]  chs_len, gsh_len, hist_len, bim_len;

  hbp_pkg::rsp_t predicted_rsp_q [$];

  // Address pool that shapes the random traffic into recurring branches.
  logic [hbp_pkg::ADDR_W-1:0] pool_addr   [POOL_SIZE];
  outcome_style_e             pool_style  [POOL_SIZE];
  int unsigned                pool_period [POOL_SIZE];
  int unsigned                pool_visits [POOL_SIZE];
  logic                       last_outcome;

  bit          tx_idling;
  bit          rx_idling;
  bit          hold_rsp_long;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned branches_sent;
  int unsigned responses_checked;
  int unsigned gshare_picks;
  int unsigned mispredicts_seen;
  int unsigned request_waits;
  int unsigned settings_written;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count,
               predicted_rsp_q.size());
      $display("[hybrid_branch_predictor_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [hbp_pkg::HIST_W-1:0] width_mask(
      input logic [hbp_pkg::CFG_W-1:0] bits, input int unsigned limit);
    int unsigned b;
    b = (bits > limit) ? limit : bits;
    return hbp_pkg::HIST_W'((1 << b) - 1);
  endfunction

  function automatic logic [hbp_pkg::CTR_W-1:0] saturate_step(
      input logic [hbp_pkg::CTR_W-1:0] v, input logic up,
      input logic [hbp_pkg::CTR_W-1:0] top);
    if (up) return (v >= top) ? top : v + 1'b1;
    return (v == '0) ? v : v - 1'b1;
  endfunction

  // Look up all three tables for one resolved branch, train the chosen counter,
  // the chooser and the history, and hand back the response the block owes.
  function automatic hbp_pkg::rsp_t predict_branch(input hbp_pkg::req_t br);
    logic [hbp_pkg::ADDR_W-3:0] word;
    logic [hbp_pkg::HIST_W-1:0] hmask, gmask, hist, g_idx, b_idx, c_idx;
    int unsigned                hbits;
    logic                       use_g, g_guess, b_guess, g_ok, b_ok;
    hbp_pkg::rsp_t              r;
    word  = br.branch_address[hbp_pkg::ADDR_W-1:2];
    hbits = (hist_len > hbp_pkg::HIST_W) ? hbp_pkg::HIST_W : hist_len;
    hmask = width_mask(hist_len, hbp_pkg::HIST_W);
    hist  = global_hist & hmask;
    gmask = width_mask(gsh_len, hbp_pkg::DEF_GSHARE_BITS);
    g_idx = (word[hbp_pkg::HIST_W-1:0] & gmask) ^ hist;
    g_idx = g_idx & gmask;
    b_idx = word[hbp_pkg::HIST_W-1:0] & width_mask(bim_len, hbp_pkg::DEF_BIMODAL_BITS);
    c_idx = word[hbp_pkg::HIST_W-1:0] & width_mask(chs_len, hbp_pkg::DEF_CHOOSER_BITS);

    use_g   = chooser_ctr[c_idx] >= hbp_pkg::GSHARE_AT;
    g_guess = gshare_ctr[g_idx] >= hbp_pkg::TAKEN_AT;
    b_guess = bimodal_ctr[b_idx] >= hbp_pkg::TAKEN_AT;
    g_ok    = g_guess == br.taken;
    b_ok    = b_guess == br.taken;

    // Train only the component that made the call.
    if (use_g) begin
      gshare_ctr[g_idx] = saturate_step(gshare_ctr[g_idx], br.taken, hbp_pkg::CTR_MAX);
    end else begin
      bimodal_ctr[b_idx] = saturate_step(bimodal_ctr[b_idx], br.taken, hbp_pkg::CTR_MAX);
    end

    // Shift the history right, outcome enters at the top of the current length.
    hist = hist >> 1;
    if (br.taken && hbits > 0) hist[hbits-1] = 1'b1;
    global_hist = hist & hmask;

    // Move the chooser toward whichever component alone was right.
    if (g_ok && !b_ok) begin
      chooser_ctr[c_idx] = hbp_pkg::CHS_W'(saturate_step(
          hbp_pkg::CTR_W'(chooser_ctr[c_idx]), 1'b1, hbp_pkg::CTR_W'(hbp_pkg::CHS_MAX)));
    end else if (b_ok && !g_ok) begin
      chooser_ctr[c_idx] = hbp_pkg::CHS_W'(saturate_step(
          hbp_pkg::CTR_W'(chooser_ctr[c_idx]), 1'b0, hbp_pkg::CTR_W'(hbp_pkg::CHS_MAX)));
    end

    r.predicted_taken = use_g ? g_guess : b_guess;
    r.used_gshare     = use_g;
    r.gshare_guess    = g_guess;
    r.bimodal_guess   = b_guess;
    r.mispredicted    = r.predicted_taken != br.taken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one branch, hold it until accepted, then record its prediction.
  // Leave valid high afterwards unless an idle burst follows.
  task automatic send_branch(input logic [hbp_pkg::ADDR_W-1:0] addr, input logic tkn);
    hbp_pkg::req_t item;
    item.branch_address = addr;
    item.taken          = tkn;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready_o);
    predicted_rsp_q = {predicted_rsp_q, predict_branch(item)};
    branches_sent++;
    last_outcome = tkn;
    if (tx_idling && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every response is back and the pipe is empty.
  task automatic drain_block();
    req_valid <= 1'b0;
    while (predicted_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive one register write and mirror it into the predictor.
  task automatic put_reg(input hbp_pkg::cfg_reg_e r, input logic [hbp_pkg::CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      hbp_pkg::REG_CHOOSER_BITS: chs_len = v;
      hbp_pkg::REG_GSHARE_BITS:  gsh_len = v;
      hbp_pkg::REG_HISTORY_BITS: hist_len = v;
      hbp_pkg::REG_BIMODAL_BITS: bim_len = v;
      default: ;
    endcase
  endtask

  // Write all four widths back to back; call only with the block drained.
  task automatic write_widths(input logic [hbp_pkg::CFG_W-1:0] c,
                              input logic [hbp_pkg::CFG_W-1:0] g,
                              input logic [hbp_pkg::CFG_W-1:0] h,
                              input logic [hbp_pkg::CFG_W-1:0] b);
    put_reg(hbp_pkg::REG_CHOOSER_BITS, c);
    put_reg(hbp_pkg::REG_GSHARE_BITS, g);
    put_reg(hbp_pkg::REG_HISTORY_BITS, h);
    put_reg(hbp_pkg::REG_BIMODAL_BITS, b);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // Mostly legal widths, now and then zero or an oversized value.
  function automatic logic [hbp_pkg::CFG_W-1:0] pick_width();
    if ($urandom_range(0, 9) == 0) return hbp_pkg::CFG_W'($urandom_range(0, 15));
    return hbp_pkg::CFG_W'($urandom_range(1, 12));
  endfunction

  task automatic reseed_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_addr[i]   = $urandom;
      pool_style[i]  = outcome_style_e'($urandom_range(0, 4));
      pool_period[i] = $urandom_range(2, 6);
      pool_visits[i] = 0;
    end
  endtask

  // Send n branches: most revisit the pool with a structured outcome, the
  // rest are noise at random addresses.
  task automatic run_traffic(input int unsigned n);
    int unsigned slot;
    logic        tkn;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        send_branch($urandom, 1'($urandom));
      end else begin
        slot = $urandom_range(0, POOL_SIZE - 1);
        case (pool_style[slot])
          LOOP_TAKEN:     tkn = 1'b1;
          LOOP_NOT_TAKEN: tkn = 1'b0;
          LOOP_EXIT:      tkn = (pool_visits[slot] % pool_period[slot]) !=
                                (pool_period[slot] - 1);
          CORRELATED:     tkn = last_outcome;
          default:        tkn = 1'($urandom);
        endcase
        pool_visits[slot]++;
        send_branch(pool_addr[slot], tkn);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------
  // Stall in short random bursts when allowed; on request hold off for a long
  // stretch so the lookup stage fills and the block pushes back.
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rsp_long) begin
        rsp_ready <= 1'b0;
        for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
        hold_rsp_long = 1'b0;
        rsp_ready <= 1'b1;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("Mismatch at response %0d (cycle %0d): %s", responses_checked, cycle_count,
               what);
    end
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want) report_mismatch($sformatf("%s is %b, predicted %b", name, got, want));
  endtask

  // Compare every accepted response with the oldest prediction.
  always @(posedge clk) begin : check_responses
    hbp_pkg::rsp_t want;
    if (rst_n) begin
      if (req_valid && !req_ready_o) request_waits++;
      if (rsp_valid_o && rsp_ready) begin
        if (predicted_rsp_q.size() == 0) begin
          report_mismatch("response with no branch outstanding");
        end else begin
          want = predicted_rsp_q.pop_front();
          check_field("predicted_taken", rsp_o.predicted_taken, want.predicted_taken);
          check_field("used_gshare", rsp_o.used_gshare, want.used_gshare);
          check_field("gshare_guess", rsp_o.gshare_guess, want.gshare_guess);
          check_field("bimodal_guess", rsp_o.bimodal_guess, want.bimodal_guess);
          check_field("mispredicted", rsp_o.mispredicted, want.mispredicted);
        end
        responses_checked++;
        if (rsp_o.used_gshare) gshare_picks++;
        if (rsp_o.mispredicted) mispredicts_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset widths: address extremes, ignored low bits, both outcomes, repeats
  // at one address so counters and chooser move off their reset values.
  task automatic test_reset_widths();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0003, 1'b0);
    send_branch(32'h8000_0000, 1'b1);
    send_branch(32'h5555_5555, 1'b0);
    send_branch(32'hAAAA_AAAA, 1'b1);
    send_branch(32'h0000_3FFC, 1'b1);
    drain_block();
  endtask

  // Zero widths, oversized widths and history longer than the gshare index.
  task automatic test_width_extremes();
    write_widths('0, '0, '0, '0);
    send_branch(32'h1234_5678, 1'b1);
    send_branch(32'hFFFF_FFFC, 1'b0);
    send_branch(32'h0000_0000, 1'b1);
    drain_block();
    write_widths(4'd15, 4'd15, 4'd15, 4'd15);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_4000, 1'b0);
    send_branch(32'hDEAD_BEEC, 1'b1);
    drain_block();
    write_widths(4'd1, 4'd3, 4'd12, 4'd12);
    send_branch(32'h0000_001C, 1'b1);
    send_branch(32'h0000_001C, 1'b1);
    send_branch(32'h0000_001C, 1'b0);
    send_branch(32'hFFFF_FFE0, 1'b1);
    drain_block();
  endtask

  // Several phases, each with its own widths, idling mix and address pool.
  // Tables carry over between phases, as they do in the block.
  task automatic test_random_phases(input int unsigned phases, input int unsigned n);
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: write_widths(4'd12, 4'd12, 4'd12, 4'd12);
        1: write_widths(4'd1, 4'd1, 4'd1, 4'd1);
        2: write_widths(hbp_pkg::RST_CHOOSER_BITS, hbp_pkg::RST_GSHARE_BITS,
                        hbp_pkg::RST_HISTORY_BITS, hbp_pkg::RST_BIMODAL_BITS);
        3: write_widths(4'd4, 4'd2, 4'd12, 4'd3);
        default: write_widths(pick_width(), pick_width(), pick_width(), pick_width());
      endcase
      tx_idling = $urandom_range(0, 3) != 0;
      rx_idling = $urandom_range(0, 3) != 0;
      reseed_pool();
      run_traffic(n);
      drain_block();
    end
  endtask

  // Hold the response side off while requests keep coming, so the block has
  // to stall its input.
  task automatic test_backpressure();
    write_widths(pick_width(), pick_width(), pick_width(), pick_width());
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    reseed_pool();
    hold_rsp_long = 1'b1;
    run_traffic(40);
    drain_block();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    write_widths(pick_width(), pick_width(), pick_width(), pick_width());
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    reseed_pool();
    run_traffic(250);
    drain_block();
  endtask

  initial begin : main_seq
    rst_n     <= 1'b0;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= hbp_pkg::REG_CHOOSER_BITS;
    cfg_wdata <= '0;

    // Mirror the block's reset state.
    foreach (chooser_ctr[i]) chooser_ctr[i] = hbp_pkg::CHS_RESET;
    foreach (gshare_ctr[i]) gshare_ctr[i] = hbp_pkg::CTR_RESET;
    foreach (bimodal_ctr[i]) bimodal_ctr[i] = hbp_pkg::CTR_RESET;
    global_hist  = '0;
    chs_len      = hbp_pkg::RST_CHOOSER_BITS;
    gsh_len      = hbp_pkg::RST_GSHARE_BITS;
    hist_len     = hbp_pkg::RST_HISTORY_BITS;
    bim_len      = hbp_pkg::RST_BIMODAL_BITS;
    last_outcome = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clearing pass after reset shows up as a long wait on the first send.
    test_reset_widths();
    test_width_extremes();
    test_random_phases(8, 120);
    test_backpressure();
    test_full_rate();

    $display("Sent %0d branches under %0d width settings, checked %0d responses",
             branches_sent, settings_written, responses_checked);
    $display("Gshare chosen %0d times, %0d mispredicts, %0d cycles of request stall",
             gshare_picks, mispredicts_seen, request_waits);
    if (mismatches == 0) begin
      $display("[hybrid_branch_predictor_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[hybrid_branch_predictor_top] ERROR");
    end
    $finish;
  end

endmodule
